// ===== rtl/rfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg: shared types and constants of the record frame parser
// Frame phases, result event codes, header byte positions and the
// result bundle handed from the parser to the output register.
// ----------------------------------------------------------------------------
package rfp_pkg;

  // Parse phase; the unused fourth code acts as the frame header phase.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_RECHEAD = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EV_ELEMENT      = 2'd0,
    EV_FRAME_END    = 2'd1,
    EV_HDR_MISMATCH = 2'd2,
    EV_BAD_SIZE     = 2'd3
  } event_e;

  // Byte positions within the 5-byte frame header (last byte is the default)
  localparam logic [2:0] HDR_SYNC_LO = 3'd0;
  localparam logic [2:0] HDR_SYNC_HI = 3'd1;
  localparam logic [2:0] HDR_BUF_ID  = 3'd2;
  localparam logic [2:0] HDR_CNT_LO  = 3'd3;

  // Byte positions within the 3-byte record header
  localparam logic [2:0] REC_ID   = 3'd0;
  localparam logic [2:0] REC_SIZE = 3'd1;

  // Legal element sizes in bytes
  localparam logic [7:0] ELEM_SIZE_1 = 8'd1;
  localparam logic [7:0] ELEM_SIZE_2 = 8'd2;
  localparam logic [7:0] ELEM_SIZE_4 = 8'd4;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  record_id;
    logic [7:0]  element_index;
    logic [31:0] element_value;
    logic [2:0]  element_size;
    logic        last_in_record;
    logic        last_in_frame;
  } result_t;

endpackage

// ===== rtl/rfp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_parser: frame parse state and per-byte step
// Holds the frame/record state and works out, for the byte being
// transferred, the next state and the (at most one) result it causes.
// ----------------------------------------------------------------------------
module rfp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [15:0]      sync_word_i,
  output logic             res_valid_o,
  output rfp_pkg::result_t res_o
);

  rfp_pkg::phase_e phase_q, phase_d;
  logic [2:0]  fbc_q, fbc_d;
  logic [7:0]  sync_lo_q, sync_lo_d;
  logic        sync_bad_q, sync_bad_d;
  logic [7:0]  buf_id_q, buf_id_d;
  logic [15:0] rec_left_q, rec_left_d;
  logic [7:0]  rec_id_q, rec_id_d;
  logic [7:0]  elem_size_q, elem_size_d;
  logic [7:0]  elem_count_q, elem_count_d;
  logic [15:0] pay_left_q, pay_left_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  elem_cnt_q, elem_cnt_d;
  logic        supp_q, supp_d;

  // shared terms
  logic        rec_last;
  logic [15:0] pay_dec;
  logic        pay_done;
  logic [15:0] pay_new;
  logic [31:0] acc_ins;
  logic        elem_done;
  logic        size_ok;
  logic [15:0] rec_full;

  assign rec_last  = (rec_left_q <= 16'd1);
  assign pay_dec   = (pay_left_q != 16'd0) ? (pay_left_q - 16'd1) : 16'd0;
  assign pay_done  = (pay_dec == 16'd0);
  assign pay_new   = {8'd0, elem_size_q} * {8'd0, rx_byte_i};
  assign acc_ins   = acc_q | ({24'd0, rx_byte_i} << {byte_idx_q, 3'b000});
  assign elem_done = (({6'd0, byte_idx_q} + 8'd1) >= elem_size_q);
  assign size_ok   = (elem_size_q == rfp_pkg::ELEM_SIZE_1) ||
                     (elem_size_q == rfp_pkg::ELEM_SIZE_2) ||
                     (elem_size_q == rfp_pkg::ELEM_SIZE_4);
  assign rec_full  = {rx_byte_i, rec_left_q[7:0]};

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      rfp_pkg::PH_PAYLOAD: begin
        if (pay_done) begin
          phase_d = rec_last ? rfp_pkg::PH_HEADER : rfp_pkg::PH_RECHEAD;
        end
      end
      rfp_pkg::PH_RECHEAD: begin
        if (fbc_q != rfp_pkg::REC_ID && fbc_q != rfp_pkg::REC_SIZE) begin
          if (pay_new == 16'd0) begin
            phase_d = rec_last ? rfp_pkg::PH_HEADER : rfp_pkg::PH_RECHEAD;
          end else begin
            phase_d = rfp_pkg::PH_PAYLOAD;
          end
        end
      end
      default: begin
        phase_d = rfp_pkg::PH_HEADER;
        if (fbc_q != rfp_pkg::HDR_SYNC_LO && fbc_q != rfp_pkg::HDR_SYNC_HI &&
            fbc_q != rfp_pkg::HDR_BUF_ID && fbc_q != rfp_pkg::HDR_CNT_LO &&
            !sync_bad_q) begin
          phase_d = rfp_pkg::PH_RECHEAD;
        end
      end
    endcase
  end

  // datapath next values and result
  always_comb begin
    fbc_d        = fbc_q;
    sync_lo_d    = sync_lo_q;
    sync_bad_d   = sync_bad_q;
    buf_id_d     = buf_id_q;
    rec_left_d   = rec_left_q;
    rec_id_d     = rec_id_q;
    elem_size_d  = elem_size_q;
    elem_count_d = elem_count_q;
    pay_left_d   = pay_left_q;
    byte_idx_d   = byte_idx_q;
    acc_d        = acc_q;
    elem_cnt_d   = elem_cnt_q;
    supp_d       = supp_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    res_o.ev     = rfp_pkg::EV_ELEMENT;

    unique case (phase_q)
      rfp_pkg::PH_PAYLOAD: begin
        if (!supp_q) begin
          if (elem_done) begin
            res_valid_o          = 1'b1;
            res_o.ev             = rfp_pkg::EV_ELEMENT;
            res_o.record_id      = rec_id_q;
            res_o.element_index  = elem_cnt_q;
            res_o.element_value  = acc_ins;
            res_o.element_size   = elem_size_q[2:0];
            res_o.last_in_record = (({1'b0, elem_cnt_q} + 9'd1) == {1'b0, elem_count_q});
            res_o.last_in_frame  = (pay_left_q <= 16'd1) && rec_last;
            elem_cnt_d           = elem_cnt_q + 8'd1;
            byte_idx_d           = 2'd0;
            acc_d                = '0;
          end else begin
            byte_idx_d = byte_idx_q + 2'd1;
            acc_d      = acc_ins;
          end
        end
        pay_left_d = pay_dec;
        if (pay_done) begin
          fbc_d = '0;
          if (rec_last) begin
            rec_left_d = '0;
            if (!res_valid_o) begin
              res_valid_o         = 1'b1;
              res_o               = '0;
              res_o.ev            = rfp_pkg::EV_FRAME_END;
              res_o.last_in_frame = 1'b1;
            end
          end else begin
            rec_left_d = rec_left_q - 16'd1;
          end
        end
      end

      rfp_pkg::PH_RECHEAD: begin
        if (fbc_q == rfp_pkg::REC_ID) begin
          rec_id_d = rx_byte_i;
          fbc_d    = rfp_pkg::REC_SIZE;
        end else if (fbc_q == rfp_pkg::REC_SIZE) begin
          elem_size_d = rx_byte_i;
          fbc_d       = 3'd2;
        end else begin
          elem_count_d = rx_byte_i;
          fbc_d        = '0;
          pay_left_d   = pay_new;
          elem_cnt_d   = '0;
          byte_idx_d   = '0;
          acc_d        = '0;
          if (!supp_q && rx_byte_i != 8'd0 && !size_ok) begin
            res_valid_o     = 1'b1;
            res_o.ev        = rfp_pkg::EV_BAD_SIZE;
            res_o.record_id = rec_id_q;
            supp_d          = 1'b1;
          end
          if (pay_new == 16'd0) begin
            if (rec_last) begin
              rec_left_d = '0;
              if (res_valid_o) begin
                res_o.last_in_frame = 1'b1;
              end else begin
                res_valid_o         = 1'b1;
                res_o.ev            = rfp_pkg::EV_FRAME_END;
                res_o.last_in_frame = 1'b1;
              end
            end else begin
              rec_left_d = rec_left_q - 16'd1;
            end
          end
        end
      end

      default: begin
        priority case (fbc_q)
          rfp_pkg::HDR_SYNC_LO: begin
            sync_lo_d = rx_byte_i;
            fbc_d     = rfp_pkg::HDR_SYNC_HI;
          end
          rfp_pkg::HDR_SYNC_HI: begin
            sync_bad_d = ({rx_byte_i, sync_lo_q} != sync_word_i);
            fbc_d      = rfp_pkg::HDR_BUF_ID;
          end
          rfp_pkg::HDR_BUF_ID: begin
            buf_id_d = rx_byte_i;
            fbc_d    = rfp_pkg::HDR_CNT_LO;
          end
          rfp_pkg::HDR_CNT_LO: begin
            rec_left_d = {8'd0, rx_byte_i};
            fbc_d      = 3'd4;
          end
          default: begin
            fbc_d = '0;
            if (sync_bad_q) begin
              rec_left_d          = '0;
              res_valid_o         = 1'b1;
              res_o.ev            = rfp_pkg::EV_HDR_MISMATCH;
              res_o.last_in_frame = 1'b1;
            end else begin
              // a record count of zero means one record
              rec_left_d = (rec_full == 16'd0) ? 16'd1 : rec_full;
              supp_d     = (buf_id_q != 8'd0);
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= rfp_pkg::PH_HEADER;
      fbc_q        <= '0;
      sync_lo_q    <= '0;
      sync_bad_q   <= 1'b0;
      buf_id_q     <= '0;
      rec_left_q   <= '0;
      rec_id_q     <= '0;
      elem_size_q  <= '0;
      elem_count_q <= '0;
      pay_left_q   <= '0;
      byte_idx_q   <= '0;
      acc_q        <= '0;
      elem_cnt_q   <= '0;
      supp_q       <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      fbc_q        <= fbc_d;
      sync_lo_q    <= sync_lo_d;
      sync_bad_q   <= sync_bad_d;
      buf_id_q     <= buf_id_d;
      rec_left_q   <= rec_left_d;
      rec_id_q     <= rec_id_d;
      elem_size_q  <= elem_size_d;
      elem_count_q <= elem_count_d;
      pay_left_q   <= pay_left_d;
      byte_idx_q   <= byte_idx_d;
      acc_q        <= acc_d;
      elem_cnt_q   <= elem_cnt_d;
      supp_q       <= supp_d;
    end
  end

endmodule

// ===== rtl/record_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_frame_parser_core: byte-serial record frame parser
// Checks each frame's sync word, walks its record headers and emits the
// little-endian elements of 1, 2 or 4 bytes with record id and index,
// plus frame-end, header-mismatch and bad-size events.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                               | Transfer when
//  ---------+-------------------------------------+---------------------------
//  in       | in_valid_i, in_ready_o, rx_byte_i   | in_valid_i & in_ready_o
//  out      | out_valid_o, out_ready_i, fields    | out_valid_o & out_ready_i
//  cfg      | cfg_we_i, cfg_wdata_i (sync word)   | cfg_we_i
//
//  One byte per cycle while in_ready_o is high: each byte's state update and
//  element shift fit in the cycle it is transferred in; its result appears
//  in the output register on the next cycle.
//  A new byte is taken while the output register is empty or being
//  drained the same cycle; only a stalled full output holds off input.
//  Reset clears all parse state to the frame header phase, the sync word
//  register to zero and the output register to empty.
//
module record_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // sync word register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [7:0]  record_id_o,
  output logic [7:0]  element_index_o,
  output logic [31:0] element_value_o,
  output logic [2:0]  element_size_o,
  output logic        last_in_record_o,
  output logic        last_in_frame_o
);

  logic [15:0]      sync_word_q;
  logic             in_fire;
  logic             res_valid;
  rfp_pkg::result_t res;
  logic             out_valid_q;
  rfp_pkg::result_t out_q;

  // input stalls only behind a result that is not being taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= '0;
    end else if (cfg_we_i) begin
      sync_word_q <= cfg_wdata_i;
    end
  end

  rfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .rx_byte_i   (rx_byte_i),
    .sync_word_i (sync_word_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register: loaded on every input transfer, emptied when drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = out_q.ev;
  assign record_id_o      = out_q.record_id;
  assign element_index_o  = out_q.element_index;
  assign element_value_o  = out_q.element_value;
  assign element_size_o   = out_q.element_size;
  assign last_in_record_o = out_q.last_in_record;
  assign last_in_frame_o  = out_q.last_in_frame;

endmodule
